>>> hw/rtl/rdm_pkg.sv
package rdm_pkg;

    localparam int COEF_W    = 32;
    localparam int COORD_W   = 32;
    localparam int TAB_DEPTH = 36;
    localparam int SET_SIZE  = 18;
    localparam int ROW_SIZE  = 6;
    localparam int IDX_W     = 6;
    localparam int SUM_W     = 98;
    localparam int NUM_W     = SUM_W + 16;
    localparam int Q_W       = 32;
    localparam int CMP_W     = SUM_W + Q_W;
    localparam int PADDR_W   = 3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    localparam logic REG_DIRECTION = 1'b0;

    typedef struct packed {
        logic                        action;
        logic [IDX_W-1:0]            coef_index;
        logic signed [COEF_W-1:0]    coef_value;
        logic signed [COORD_W-1:0]   in_x;
        logic signed [COORD_W-1:0]   in_y;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   out_x;
        logic signed [COORD_W-1:0]   out_y;
        logic                        zero_divisor;
        logic                        saturated;
    } res_t;

    typedef logic [SET_SIZE-1:0][COEF_W-1:0] coef_set_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [SUM_W-1:0] d;
        logic [Q_W-1:0]   qx;
        logic [Q_W-1:0]   qy;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
        logic             ovf_x;
        logic             ovf_y;
    } div_t;

endpackage

>>> hw/rtl/rdm_front.sv
module rdm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           take,
    input  logic signed [31:0]             x,
    input  logic signed [31:0]             y,
    input  rdm_pkg::coef_set_t             coefs,
    output logic                           valid,
    output logic signed [rdm_pkg::SUM_W-1:0] num_x,
    output logic signed [rdm_pkg::SUM_W-1:0] num_y,
    output logic signed [rdm_pkg::SUM_W-1:0] den
);
    import rdm_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    coef_set_t          c1_reg, c2_reg;
    logic signed [63:0] t2_reg [3];

    logic signed [63:0] qh3_reg [3][3];
    logic signed [64:0] ql3_reg [3][3];
    logic signed [63:0] lx3_reg [3];
    logic signed [63:0] ly3_reg [3];
    logic signed [31:0] c53_reg [3];

    logic signed [SUM_W-1:0] qt4_reg [3][3];
    logic signed [SUM_W-1:0] ln4_reg [3];

    logic signed [SUM_W-1:0] row5_reg [3];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // capture point and the selected set
            x1_reg <= x;
            y1_reg <= y;
            c1_reg <= coefs;

            // quadratic terms
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            c2_reg    <= c1_reg;
            t2_reg[0] <= x1_reg * x1_reg;
            t2_reg[1] <= x1_reg * y1_reg;
            t2_reg[2] <= y1_reg * y1_reg;

            // split products
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qh3_reg[r][k] <= $signed(t2_reg[k][63:32])
                                     * $signed(c2_reg[r*ROW_SIZE+k]);
                    ql3_reg[r][k] <= $signed({1'b0, t2_reg[k][31:0]})
                                     * $signed(c2_reg[r*ROW_SIZE+k]);
                end
                lx3_reg[r] <= x2_reg * $signed(c2_reg[r*ROW_SIZE+3]);
                ly3_reg[r] <= y2_reg * $signed(c2_reg[r*ROW_SIZE+4]);
                c53_reg[r] <= $signed(c2_reg[r*ROW_SIZE+5]);
            end

            // rebuild terms at scale 2^-60
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qt4_reg[r][k] <= (SUM_W'(qh3_reg[r][k]) <<< 32)
                                     + SUM_W'(ql3_reg[r][k]);
                end
                ln4_reg[r] <= (SUM_W'(lx3_reg[r]) <<< 16) + (SUM_W'(ly3_reg[r]) <<< 16)
                              + (SUM_W'(c53_reg[r]) <<< 32);
            end

            // row sums
            for (int r = 0; r < 3; r++)
            begin
                row5_reg[r] <= qt4_reg[r][0] + qt4_reg[r][1] + qt4_reg[r][2]
                               + ln4_reg[r];
            end
        end
    end

    assign valid = v5_reg;
    assign num_x = row5_reg[0];
    assign num_y = row5_reg[1];
    assign den   = row5_reg[2];

endmodule

>>> hw/rtl/rdm_div_stage.sv
module rdm_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  rdm_pkg::div_t in_d,
    output logic          out_v,
    output rdm_pkg::div_t out_d
);
    import rdm_pkg::*;

    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rx, ry;
    div_t             nxt;
    logic             v_reg;
    div_t             d_reg;

    // one quotient bit per axis
    always_comb
    begin
        dsh = CMP_W'(in_d.d) << SHIFT;
        rx  = CMP_W'(in_d.rem_x);
        ry  = CMP_W'(in_d.rem_y);
        nxt = in_d;
        if (rx >= dsh)
        begin
            nxt.rem_x     = NUM_W'(rx - dsh);
            nxt.qx[SHIFT] = 1'b1;
        end
        if (ry >= dsh)
        begin
            nxt.rem_y     = NUM_W'(ry - dsh);
            nxt.qy[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= nxt;
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

>>> hw/rtl/rational_distortion_map_unit.sv
// Rational lens distortion mapper. Each map request carries a Q16.16 point and
// returns one result: the point pushed through a second-order rational model
// (two numerator rows over a shared denominator, Q4.28 coefficients), with
// zero_divisor set and zero outputs when the denominator is exactly zero and
// saturated set when a quotient is clipped. Load requests write one coefficient
// (index 0..35, higher indexes are dropped) and return nothing. The APB register
// direction (address 0) selects the correction (0) or distortion (1) set; write
// it only while the unit is idle. The unit takes one request per clock while not
// stalled; a map result passes through stages of multiply, sum and sign handling,
// then the 32-stage restoring divider (one quotient bit per stage) and the output
// register. The pipeline stalls only when the output register holds an untaken
// result and the last stage is occupied.
module rational_distortion_map_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  rdm_pkg::req_t                 req_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output rdm_pkg::res_t                 res_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rdm_pkg::*;

    logic                           direction_reg;
    logic [TAB_DEPTH-1:0][COEF_W-1:0] coef_tab_reg;

    logic      pipe_en;
    logic      accept;
    coef_set_t cur_set;

    logic                    f_v;
    logic signed [SUM_W-1:0] f_nx, f_ny, f_den;

    logic             v6_reg;
    logic [NUM_W-1:0] nx6_reg, ny6_reg;
    logic [SUM_W-1:0] d6_reg;
    logic             negx6_reg, negy6_reg, zero6_reg;

    logic  v7_reg;
    div_t  d7_reg;

    logic  vchain [Q_W+1];
    div_t  dchain [Q_W+1];

    logic  res_valid_reg;
    res_t  res_data_reg;
    res_t  res_next;

    logic [SUM_W-1:0] mag_x, mag_y, mag_d;
    logic [Q_W-1:0]   lim_x, lim_y;
    logic             sat_x, sat_y;
    logic [Q_W-1:0]   val_x, val_y;

    // APB register: index is paddr divided by four
    assign pready = 1'b1;
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_DIRECTION)
            prdata = {31'd0, direction_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION)
            direction_reg <= pwdata[0];
    end

    // advance unless a held result would be overwritten
    assign pipe_en   = !(res_valid_reg && !res_ready && vchain[Q_W]);
    assign req_ready = pipe_en;
    assign accept    = req_valid && req_ready;

    // coefficient table; a map request reads its set at acceptance,
    // so a later load never reaches an earlier point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_tab_reg <= '0;
        else if (accept && req_data.action == ACT_LOAD
                 && req_data.coef_index < IDX_W'(TAB_DEPTH))
            coef_tab_reg[req_data.coef_index] <= req_data.coef_value;
    end

    assign cur_set = direction_reg ? coef_tab_reg[TAB_DEPTH-1:SET_SIZE]
                                   : coef_tab_reg[SET_SIZE-1:0];

    rdm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_en),
        .take  (accept && req_data.action == ACT_MAP),
        .x     (req_data.in_x),
        .y     (req_data.in_y),
        .coefs (cur_set),
        .valid (f_v),
        .num_x (f_nx),
        .num_y (f_ny),
        .den   (f_den)
    );

    // magnitudes and signs
    assign mag_x = f_nx[SUM_W-1]  ? SUM_W'(-f_nx)  : SUM_W'(f_nx);
    assign mag_y = f_ny[SUM_W-1]  ? SUM_W'(-f_ny)  : SUM_W'(f_ny);
    assign mag_d = f_den[SUM_W-1] ? SUM_W'(-f_den) : SUM_W'(f_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v6_reg <= f_v;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            nx6_reg   <= {mag_x, 16'd0};
            ny6_reg   <= {mag_y, 16'd0};
            d6_reg    <= mag_d;
            negx6_reg <= f_nx[SUM_W-1] ^ f_den[SUM_W-1];
            negy6_reg <= f_ny[SUM_W-1] ^ f_den[SUM_W-1];
            zero6_reg <= (f_den == '0);

            // quotient of 2^32 or more saturates outright
            d7_reg.rem_x <= nx6_reg;
            d7_reg.rem_y <= ny6_reg;
            d7_reg.d     <= d6_reg;
            d7_reg.qx    <= '0;
            d7_reg.qy    <= '0;
            d7_reg.neg_x <= negx6_reg;
            d7_reg.neg_y <= negy6_reg;
            d7_reg.zero  <= zero6_reg;
            d7_reg.ovf_x <= CMP_W'(nx6_reg) >= (CMP_W'(d6_reg) << Q_W);
            d7_reg.ovf_y <= CMP_W'(ny6_reg) >= (CMP_W'(d6_reg) << Q_W);
        end
    end

    assign vchain[0] = v7_reg;
    assign dchain[0] = d7_reg;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        rdm_div_stage #(.SHIFT(Q_W - 1 - j)) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_en),
            .in_v  (vchain[j]),
            .in_d  (dchain[j]),
            .out_v (vchain[j+1]),
            .out_d (dchain[j+1])
        );
    end

    // clip, apply sign, handle zero denominator
    always_comb
    begin
        lim_x = dchain[Q_W].neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        lim_y = dchain[Q_W].neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat_x = dchain[Q_W].ovf_x || dchain[Q_W].qx > lim_x;
        sat_y = dchain[Q_W].ovf_y || dchain[Q_W].qy > lim_y;
        val_x = sat_x ? lim_x : dchain[Q_W].qx;
        val_y = sat_y ? lim_y : dchain[Q_W].qy;
        res_next.out_x        = dchain[Q_W].neg_x ? -val_x : val_x;
        res_next.out_y        = dchain[Q_W].neg_y ? -val_y : val_y;
        res_next.zero_divisor = 1'b0;
        res_next.saturated    = sat_x || sat_y;
        if (dchain[Q_W].zero)
        begin
            res_next.out_x        = '0;
            res_next.out_y        = '0;
            res_next.zero_divisor = 1'b1;
            res_next.saturated    = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (!res_valid_reg || res_ready)
            res_valid_reg <= vchain[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (!res_valid_reg || res_ready)
            res_data_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTHESIS
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.zero_divisor |->
            res_data_reg.out_x == '0 && res_data_reg.out_y == '0
            && !res_data_reg.saturated)
        else $error("zero divisor result not cleared");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vchain[Q_W] && pipe_en && !dchain[Q_W].zero
            && (dchain[Q_W].ovf_x || dchain[Q_W].ovf_y) |=>
            res_valid_reg && res_data_reg.saturated)
        else $error("quotient overflow not flagged");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready && vchain[Q_W] |=>
            vchain[Q_W] && $stable(dchain[Q_W]))
        else $error("last stage lost during stall");
`endif

endmodule
